### rtl/core/vcsp_pkg.sv
// vcsp_pkg: beat types, result kinds, status codes and chunk ids for the
// voxel chunk stream parser. Depends on nothing; used by rtl/core modules.
package vcsp_pkg;

    // Result kinds
    localparam logic [2:0] KIND_SIZE     = 3'd0;
    localparam logic [2:0] KIND_VOXEL    = 3'd1;
    localparam logic [2:0] KIND_PALETTE  = 3'd2;
    localparam logic [2:0] KIND_FINISHED = 3'd3;
    localparam logic [2:0] KIND_ERROR    = 3'd4;

    // Error status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_MAGIC = 2'd1;
    localparam logic [1:0] STATUS_NO_MAIN   = 2'd2;
    localparam logic [1:0] STATUS_NO_MODELS = 2'd3;

    // Chunk ids as little-endian words
    localparam logic [31:0] ID_VOX  = 32'h2058_4F56;
    localparam logic [31:0] ID_MAIN = 32'h4E49_414D;
    localparam logic [31:0] ID_SIZE = 32'h455A_4953;
    localparam logic [31:0] ID_XYZI = 32'h495A_5958;
    localparam logic [31:0] ID_RGBA = 32'h4142_4752;

    // Chunk content kinds
    localparam logic [1:0] CHUNK_OTHER = 2'd0;
    localparam logic [1:0] CHUNK_SIZE  = 2'd1;
    localparam logic [1:0] CHUNK_VOX   = 2'd2;
    localparam logic [1:0] CHUNK_PAL   = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } src_beat_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] coord_x;
        logic [31:0] coord_y;
        logic [31:0] coord_z;
        logic [7:0]  palette_slot;
        logic [31:0] color_word;
        logic [1:0]  status;
        logic        last_of_run;
    } res_beat_t;

endpackage

### rtl/core/voxel_chunk_stream_parser.sv
// voxel_chunk_stream_parser: top level, byte-wide voxel file parser with a
// four-beat result queue. Depends on vcsp_pkg.
//
// Usage:
//   src channel: one file byte per beat (data_byte, last_byte marks the end).
//   res channel: size, voxel, palette-write and end-of-file report beats.
//   A beat moves on a rising edge where valid is high and stall is low.
// Throughput: one byte per cycle while src_stall is low. Each byte updates
//   the parse state and pushes zero, one or two result beats into a
//   four-entry queue; the queue drains one beat per cycle while res_stall
//   is low.
// Queueing: a result is registered in the queue and offered on res in turn.
// Stall: src_stall rises when the queue holds three or more beats, so a
//   stalled receiver backs up into the byte stream with at most four
//   queued results; nothing is dropped.
// Reset: rst_n clears the parse state and empties the queue; the parser then
//   waits for the file magic. After a last byte the state returns to the same
//   reset state, ready for the next file.
module voxel_chunk_stream_parser #(
    parameter int PALETTE_ENTRIES = 255
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                src_valid,
    output logic                src_stall,
    input  vcsp_pkg::src_beat_t src_beat,
    output logic                res_valid,
    input  logic                res_stall,
    output vcsp_pkg::res_beat_t res_beat
);

    typedef enum logic [3:0] {
        PH_MAGIC, PH_VERSION, PH_MAIN_ID, PH_MAIN_LENS, PH_CHUNK_ID,
        PH_CHUNK_LENS, PH_SIZE, PH_VOX_COUNT, PH_VOX_DATA, PH_PAL, PH_SKIP,
        PH_STOP, PH_DRAIN
    } phase_t;

    localparam int QDEPTH = 4;
    localparam logic [8:0] PAL_LIMIT = 9'(PALETTE_ENTRIES);

    // Parse state
    phase_t      phase_reg,  phase_next;
    logic [1:0]  pos_reg,    pos_next;
    logic [31:0] shift_reg,  shift_next;
    logic [7:0]  widx_reg,   widx_next;
    logic [32:0] rem_reg,    rem_next;
    logic [1:0]  ckind_reg,  ckind_next;
    logic [31:0] vleft_reg,  vleft_next;
    logic [31:0] sx_reg,     sx_next;
    logic [31:0] sy_reg,     sy_next;
    logic        seen_reg,   seen_next;

    // Result queue
    vcsp_pkg::res_beat_t q_mem [QDEPTH];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] count_reg,  count_next;

    logic                src_take, res_take;
    logic                word_done;
    logic [31:0]         w;
    logic [1:0]          n_res;
    vcsp_pkg::res_beat_t res_arr [2];
    vcsp_pkg::res_beat_t r;

    assign src_stall = (count_reg > 3'(QDEPTH - 2));
    assign res_valid = (count_reg != 3'd0);
    assign res_beat  = q_mem[rd_ptr_reg];
    assign src_take  = src_valid && !src_stall;
    assign res_take  = res_valid && !res_stall;

    // Parse step for the byte at the src port
    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        shift_next = shift_reg;
        widx_next  = widx_reg;
        rem_next   = rem_reg;
        ckind_next = ckind_reg;
        vleft_next = vleft_reg;
        sx_next    = sx_reg;
        sy_next    = sy_reg;
        seen_next  = seen_reg;
        word_done  = 1'b0;
        w          = '0;
        n_res      = 2'd0;
        res_arr[0] = '0;
        res_arr[1] = '0;
        r          = '0;

        // Word assembly and chunk byte count
        if (phase_reg == PH_SKIP)
        begin
            if (rem_reg != 33'd0)
                rem_next = rem_reg - 33'd1;
            if (rem_next == 33'd0)
            begin
                phase_next = PH_CHUNK_ID;
                pos_next   = 2'd0;
                shift_next = '0;
            end
        end
        else if (phase_reg != PH_STOP && phase_reg != PH_DRAIN)
        begin
            if ((phase_reg == PH_SIZE || phase_reg == PH_VOX_COUNT ||
                 phase_reg == PH_VOX_DATA || phase_reg == PH_PAL) &&
                rem_reg != 33'd0)
                rem_next = rem_reg - 33'd1;
            if (pos_reg == 2'd3)
            begin
                word_done  = 1'b1;
                w          = {src_beat.data_byte, shift_reg[23:0]};
                shift_next = '0;
                pos_next   = 2'd0;
            end
            else
            begin
                shift_next = shift_reg | (32'(src_beat.data_byte) << {pos_reg, 3'b000});
                pos_next   = pos_reg + 2'd1;
            end
        end

        // Word handling per phase
        if (word_done)
        begin
            case (phase_reg)
                PH_MAGIC:
                begin
                    if (w == vcsp_pkg::ID_VOX)
                        phase_next = PH_VERSION;
                    else
                    begin
                        r = '0;
                        r.kind   = vcsp_pkg::KIND_ERROR;
                        r.status = vcsp_pkg::STATUS_BAD_MAGIC;
                        res_arr[n_res[0]] = r;
                        n_res = n_res + 2'd1;
                        phase_next = PH_DRAIN;
                    end
                end
                PH_VERSION:
                    phase_next = PH_MAIN_ID;
                PH_MAIN_ID:
                begin
                    if (w == vcsp_pkg::ID_MAIN)
                    begin
                        phase_next = PH_MAIN_LENS;
                        widx_next  = 8'd0;
                    end
                    else
                    begin
                        r = '0;
                        r.kind   = vcsp_pkg::KIND_ERROR;
                        r.status = vcsp_pkg::STATUS_NO_MAIN;
                        res_arr[n_res[0]] = r;
                        n_res = n_res + 2'd1;
                        phase_next = PH_DRAIN;
                    end
                end
                PH_MAIN_LENS:
                begin
                    if (widx_reg >= 8'd1)
                    begin
                        phase_next = PH_CHUNK_ID;
                        widx_next  = 8'd0;
                    end
                    else
                        widx_next = widx_reg + 8'd1;
                end
                PH_CHUNK_ID:
                begin
                    if (w == 32'd0)
                        phase_next = PH_STOP;
                    else
                    begin
                        if (w == vcsp_pkg::ID_SIZE)
                        begin
                            ckind_next = vcsp_pkg::CHUNK_SIZE;
                            seen_next  = 1'b1;
                            sx_next    = '0;
                            sy_next    = '0;
                        end
                        else if (w == vcsp_pkg::ID_XYZI)
                            ckind_next = vcsp_pkg::CHUNK_VOX;
                        else if (w == vcsp_pkg::ID_RGBA)
                            ckind_next = vcsp_pkg::CHUNK_PAL;
                        else
                            ckind_next = vcsp_pkg::CHUNK_OTHER;
                        phase_next = PH_CHUNK_LENS;
                        widx_next  = 8'd0;
                    end
                end
                PH_CHUNK_LENS:
                begin
                    if (widx_reg == 8'd0)
                    begin
                        rem_next  = {1'b0, w};
                        widx_next = 8'd1;
                    end
                    else
                    begin
                        rem_next  = rem_reg + {1'b0, w};
                        widx_next = 8'd0;
                        case (ckind_reg)
                            vcsp_pkg::CHUNK_SIZE: phase_next = PH_SIZE;
                            vcsp_pkg::CHUNK_VOX:  phase_next = PH_VOX_COUNT;
                            vcsp_pkg::CHUNK_PAL:  phase_next = PH_PAL;
                            default:
                                phase_next = (rem_next == 33'd0) ? PH_CHUNK_ID : PH_SKIP;
                        endcase
                    end
                end
                PH_SIZE:
                begin
                    if (widx_reg == 8'd0)
                    begin
                        sx_next   = w;
                        widx_next = 8'd1;
                    end
                    else if (widx_reg == 8'd1)
                    begin
                        sy_next   = w;
                        widx_next = 8'd2;
                    end
                    else
                    begin
                        r = '0;
                        r.kind    = vcsp_pkg::KIND_SIZE;
                        r.coord_x = sx_reg;
                        r.coord_y = sy_reg;
                        r.coord_z = w;
                        res_arr[n_res[0]] = r;
                        n_res = n_res + 2'd1;
                        phase_next = (rem_next == 33'd0) ? PH_CHUNK_ID : PH_SKIP;
                        widx_next  = 8'd0;
                    end
                end
                PH_VOX_COUNT:
                begin
                    vleft_next = w;
                    if (w == 32'd0)
                    begin
                        phase_next = (rem_next == 33'd0) ? PH_CHUNK_ID : PH_SKIP;
                        widx_next  = 8'd0;
                    end
                    else
                        phase_next = PH_VOX_DATA;
                end
                PH_VOX_DATA:
                begin
                    r = '0;
                    r.kind    = vcsp_pkg::KIND_VOXEL;
                    r.coord_x = {24'd0, w[7:0]};
                    r.coord_y = {24'd0, w[15:8]};
                    r.coord_z = {24'd0, w[23:16]};
                    res_arr[n_res[0]] = r;
                    n_res = n_res + 2'd1;
                    vleft_next = vleft_reg - 32'd1;
                    if (vleft_next == 32'd0)
                    begin
                        phase_next = (rem_next == 33'd0) ? PH_CHUNK_ID : PH_SKIP;
                        widx_next  = 8'd0;
                    end
                end
                PH_PAL:
                begin
                    r = '0;
                    r.kind         = vcsp_pkg::KIND_PALETTE;
                    r.palette_slot = widx_reg + 8'd1;
                    r.color_word   = w;
                    res_arr[n_res[0]] = r;
                    n_res = n_res + 2'd1;
                    if (({1'b0, widx_reg} + 9'd1) >= PAL_LIMIT)
                    begin
                        phase_next = (rem_next == 33'd0) ? PH_CHUNK_ID : PH_SKIP;
                        widx_next  = 8'd0;
                    end
                    else
                        widx_next = widx_reg + 8'd1;
                end
                default:
                begin
                end
            endcase
        end

        // End of file report, then back to the reset state
        if (src_beat.last_byte)
        begin
            r = '0;
            if (phase_next == PH_MAGIC)
            begin
                r.kind   = vcsp_pkg::KIND_ERROR;
                r.status = vcsp_pkg::STATUS_BAD_MAGIC;
                res_arr[n_res[0]] = r;
                n_res = n_res + 2'd1;
            end
            else if (phase_next == PH_VERSION || phase_next == PH_MAIN_ID)
            begin
                r.kind   = vcsp_pkg::KIND_ERROR;
                r.status = vcsp_pkg::STATUS_NO_MAIN;
                res_arr[n_res[0]] = r;
                n_res = n_res + 2'd1;
            end
            else if (phase_next != PH_DRAIN)
            begin
                if (phase_next == PH_SIZE ||
                    (phase_next == PH_CHUNK_LENS && ckind_next == vcsp_pkg::CHUNK_SIZE))
                begin
                    r.kind    = vcsp_pkg::KIND_SIZE;
                    r.coord_x = sx_next;
                    r.coord_y = sy_next;
                    res_arr[n_res[0]] = r;
                    n_res = n_res + 2'd1;
                end
                r = '0;
                if (seen_next)
                    r.kind = vcsp_pkg::KIND_FINISHED;
                else
                begin
                    r.kind   = vcsp_pkg::KIND_ERROR;
                    r.status = vcsp_pkg::STATUS_NO_MODELS;
                end
                res_arr[n_res[0]] = r;
                n_res = n_res + 2'd1;
            end
            phase_next = PH_MAGIC;
            pos_next   = 2'd0;
            shift_next = '0;
            widx_next  = 8'd0;
            rem_next   = '0;
            ckind_next = vcsp_pkg::CHUNK_OTHER;
            vleft_next = '0;
            sx_next    = '0;
            sy_next    = '0;
            seen_next  = 1'b0;
        end

        // Mark the final beat of this byte
        if (n_res == 2'd1)
            res_arr[0].last_of_run = 1'b1;
        else if (n_res == 2'd2)
            res_arr[1].last_of_run = 1'b1;
    end

    assign count_next = count_reg + (src_take ? 3'(n_res) : 3'd0) - 3'(res_take);

    // Parse state and queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_MAGIC;
            pos_reg    <= 2'd0;
            shift_reg  <= '0;
            widx_reg   <= 8'd0;
            rem_reg    <= '0;
            ckind_reg  <= vcsp_pkg::CHUNK_OTHER;
            vleft_reg  <= '0;
            sx_reg     <= '0;
            sy_reg     <= '0;
            seen_reg   <= 1'b0;
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            if (src_take)
            begin
                phase_reg  <= phase_next;
                pos_reg    <= pos_next;
                shift_reg  <= shift_next;
                widx_reg   <= widx_next;
                rem_reg    <= rem_next;
                ckind_reg  <= ckind_next;
                vleft_reg  <= vleft_next;
                sx_reg     <= sx_next;
                sy_reg     <= sy_next;
                seen_reg   <= seen_next;
                wr_ptr_reg <= wr_ptr_reg + n_res;
            end
            if (res_take)
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            count_reg <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (src_take && n_res != 2'd0)
            q_mem[wr_ptr_reg] <= res_arr[0];
        if (src_take && n_res == 2'd2)
            q_mem[wr_ptr_reg + 2'd1] <= res_arr[1];
    end

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 3'(QDEPTH))
        else $error("result queue overflow");

    a_room_on_take: assert property (@(posedge clk) disable iff (!rst_n)
        src_take |-> (count_reg <= 3'(QDEPTH - 2)))
        else $error("byte taken without room for two results");

    a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (src_take && src_beat.last_byte) |=> (phase_reg == PH_MAGIC && !seen_reg))
        else $error("parse state not reset after last byte");

    a_quiet_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (src_take && !src_beat.last_byte &&
         (phase_reg == PH_STOP || phase_reg == PH_DRAIN)) |-> (n_res == 2'd0))
        else $error("result from a stopped parser");

    a_finish_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_beat.kind == vcsp_pkg::KIND_FINISHED) |-> res_beat.last_of_run)
        else $error("finish report not last of run");

endmodule

### bench/vcsp_result_checker.sv
// vcsp_result_checker: watches the byte and result channels of the voxel chunk
// stream parser, tracks the parse on its own and compares every result beat.
// Depends on vcsp_pkg.
module vcsp_result_checker #(
    parameter int PALETTE_ENTRIES = 255
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                src_valid,
    input  logic                src_stall,
    input  vcsp_pkg::src_beat_t src_beat,
    input  logic                res_valid,
    input  logic                res_stall,
    input  vcsp_pkg::res_beat_t res_beat,
    output int                  bad_results,
    output int                  results_outstanding
);

    localparam int MAX_REPORTS = 10;

    typedef enum logic [3:0] {
        PH_MAGIC, PH_VERSION, PH_MAIN_ID, PH_MAIN_LENS, PH_CHUNK_ID, PH_CHUNK_LENS,
        PH_SIZE, PH_VOX_COUNT, PH_VOX_DATA, PH_PAL, PH_SKIP, PH_STOP, PH_DRAIN
    } parse_phase_e;

    // Shadow parse state
    parse_phase_e phase_now;
    logic [1:0]   byte_pos;
    logic [31:0]  word_acc;
    logic [7:0]   word_idx;
    logic [32:0]  bytes_left;
    logic [1:0]   chunk_sort;
    logic [31:0]  voxels_due;
    logic [31:0]  held_x;
    logic [31:0]  held_y;
    logic         size_found;

    vcsp_pkg::res_beat_t awaited[$];
    int                  mismatches;

    function automatic void clear_parse();
        phase_now  = PH_MAGIC;
        byte_pos   = '0;
        word_acc   = '0;
        word_idx   = '0;
        bytes_left = '0;
        chunk_sort = vcsp_pkg::CHUNK_OTHER;
        voxels_due = '0;
        held_x     = '0;
        held_y     = '0;
        size_found = 1'b0;
    endfunction

    function automatic void queue_result(input logic [2:0] kind, input logic [31:0] x,
                                         input logic [31:0] y, input logic [31:0] z,
                                         input logic [7:0] slot, input logic [31:0] color,
                                         input logic [1:0] status);
        vcsp_pkg::res_beat_t r;
        r.kind         = kind;
        r.coord_x      = x;
        r.coord_y      = y;
        r.coord_z      = z;
        r.palette_slot = slot;
        r.color_word   = color;
        r.status       = status;
        r.last_of_run  = 1'b0;
        awaited.push_back(r);
    endfunction

    // Content done: skip what the header still owes, else look for the next id
    function automatic void close_content();
        phase_now = (bytes_left == 0) ? PH_CHUNK_ID : PH_SKIP;
        word_idx  = '0;
    endfunction

    // One file byte: word assembly, chunk walk and end-of-file report
    function automatic void parse_file_byte(input logic [7:0] b, input logic lst);
        int          first;
        logic        done;
        logic [31:0] w;
        first = awaited.size();
        done  = 1'b0;
        w     = '0;

        if (phase_now == PH_SKIP) begin
            if (bytes_left != 0)
                bytes_left = bytes_left - 1;
            if (bytes_left == 0) begin
                phase_now = PH_CHUNK_ID;
                byte_pos  = '0;
                word_acc  = '0;
            end
        end else if (phase_now != PH_STOP && phase_now != PH_DRAIN) begin
            if (phase_now inside {PH_SIZE, PH_VOX_COUNT, PH_VOX_DATA, PH_PAL}) begin
                if (bytes_left != 0)
                    bytes_left = bytes_left - 1;
            end
            word_acc = word_acc | (32'(b) << (8 * byte_pos));
            if (byte_pos == 2'd3) begin
                done     = 1'b1;
                w        = word_acc;
                word_acc = '0;
                byte_pos = '0;
            end else begin
                byte_pos = byte_pos + 2'd1;
            end
        end

        if (done) begin
            case (phase_now)
                PH_MAGIC: begin
                    if (w == vcsp_pkg::ID_VOX) begin
                        phase_now = PH_VERSION;
                    end else begin
                        queue_result(vcsp_pkg::KIND_ERROR, '0, '0, '0, '0, '0,
                                     vcsp_pkg::STATUS_BAD_MAGIC);
                        phase_now = PH_DRAIN;
                    end
                end
                PH_VERSION: phase_now = PH_MAIN_ID;
                PH_MAIN_ID: begin
                    if (w == vcsp_pkg::ID_MAIN) begin
                        phase_now = PH_MAIN_LENS;
                        word_idx  = '0;
                    end else begin
                        queue_result(vcsp_pkg::KIND_ERROR, '0, '0, '0, '0, '0,
                                     vcsp_pkg::STATUS_NO_MAIN);
                        phase_now = PH_DRAIN;
                    end
                end
                PH_MAIN_LENS: begin
                    if (word_idx >= 1) begin
                        phase_now = PH_CHUNK_ID;
                        word_idx  = '0;
                    end else begin
                        word_idx = word_idx + 8'd1;
                    end
                end
                PH_CHUNK_ID: begin
                    if (w == 0) begin
                        phase_now = PH_STOP;
                    end else begin
                        if (w == vcsp_pkg::ID_SIZE) begin
                            chunk_sort = vcsp_pkg::CHUNK_SIZE;
                            size_found = 1'b1;
                            held_x     = '0;
                            held_y     = '0;
                        end else if (w == vcsp_pkg::ID_XYZI) begin
                            chunk_sort = vcsp_pkg::CHUNK_VOX;
                        end else if (w == vcsp_pkg::ID_RGBA) begin
                            chunk_sort = vcsp_pkg::CHUNK_PAL;
                        end else begin
                            chunk_sort = vcsp_pkg::CHUNK_OTHER;
                        end
                        phase_now = PH_CHUNK_LENS;
                        word_idx  = '0;
                    end
                end
                PH_CHUNK_LENS: begin
                    if (word_idx == 0) begin
                        bytes_left = {1'b0, w};
                        word_idx   = 8'd1;
                    end else begin
                        bytes_left = bytes_left + {1'b0, w};
                        word_idx   = '0;
                        case (chunk_sort)
                            vcsp_pkg::CHUNK_SIZE: phase_now = PH_SIZE;
                            vcsp_pkg::CHUNK_VOX:  phase_now = PH_VOX_COUNT;
                            vcsp_pkg::CHUNK_PAL:  phase_now = PH_PAL;
                            default:              close_content();
                        endcase
                    end
                end
                PH_SIZE: begin
                    if (word_idx == 0) begin
                        held_x   = w;
                        word_idx = 8'd1;
                    end else if (word_idx == 1) begin
                        held_y   = w;
                        word_idx = 8'd2;
                    end else begin
                        queue_result(vcsp_pkg::KIND_SIZE, held_x, held_y, w, '0, '0,
                                     vcsp_pkg::STATUS_OK);
                        close_content();
                    end
                end
                PH_VOX_COUNT: begin
                    voxels_due = w;
                    if (w == 0)
                        close_content();
                    else
                        phase_now = PH_VOX_DATA;
                end
                PH_VOX_DATA: begin
                    queue_result(vcsp_pkg::KIND_VOXEL, 32'(w[7:0]), 32'(w[15:8]),
                                 32'(w[23:16]), '0, '0, vcsp_pkg::STATUS_OK);
                    voxels_due = voxels_due - 1;
                    if (voxels_due == 0)
                        close_content();
                end
                PH_PAL: begin
                    queue_result(vcsp_pkg::KIND_PALETTE, '0, '0, '0, word_idx + 8'd1, w,
                                 vcsp_pkg::STATUS_OK);
                    if (32'(word_idx) + 1 >= PALETTE_ENTRIES)
                        close_content();
                    else
                        word_idx = word_idx + 8'd1;
                end
                default: ;
            endcase
        end

        // End of file report, then back to the state after reset
        if (lst) begin
            if (phase_now == PH_MAGIC) begin
                queue_result(vcsp_pkg::KIND_ERROR, '0, '0, '0, '0, '0,
                             vcsp_pkg::STATUS_BAD_MAGIC);
            end else if (phase_now == PH_VERSION || phase_now == PH_MAIN_ID) begin
                queue_result(vcsp_pkg::KIND_ERROR, '0, '0, '0, '0, '0,
                             vcsp_pkg::STATUS_NO_MAIN);
            end else if (phase_now != PH_DRAIN) begin
                if (phase_now == PH_SIZE ||
                    (phase_now == PH_CHUNK_LENS && chunk_sort == vcsp_pkg::CHUNK_SIZE))
                    queue_result(vcsp_pkg::KIND_SIZE, held_x, held_y, '0, '0, '0,
                                 vcsp_pkg::STATUS_OK);
                if (size_found)
                    queue_result(vcsp_pkg::KIND_FINISHED, '0, '0, '0, '0, '0,
                                 vcsp_pkg::STATUS_OK);
                else
                    queue_result(vcsp_pkg::KIND_ERROR, '0, '0, '0, '0, '0,
                                 vcsp_pkg::STATUS_NO_MODELS);
            end
            clear_parse();
        end

        if (awaited.size() > first)
            awaited[awaited.size() - 1].last_of_run = 1'b1;
    endfunction

    function automatic string beat_text(input vcsp_pkg::res_beat_t r);
        return $sformatf("kind=%0d x=%h y=%h z=%h slot=%0d color=%h status=%0d last=%0b",
                         r.kind, r.coord_x, r.coord_y, r.coord_z, r.palette_slot,
                         r.color_word, r.status, r.last_of_run);
    endfunction

    function automatic void check_result(input vcsp_pkg::res_beat_t got);
        vcsp_pkg::res_beat_t want;
        if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: result beat with none awaited: %s", $time, beat_text(got));
        end else begin
            want = awaited.pop_front();
            if (got.kind !== want.kind || got.coord_x !== want.coord_x ||
                got.coord_y !== want.coord_y || got.coord_z !== want.coord_z ||
                got.palette_slot !== want.palette_slot ||
                got.color_word !== want.color_word || got.status !== want.status ||
                got.last_of_run !== want.last_of_run) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("%0t: result mismatch, want %s", $time, beat_text(want));
                    $display("%0t:                  got  %s", $time, beat_text(got));
                end
            end
        end
    endfunction

    // Results pass through the parser's result queue, so compare before predicting
    always @(posedge clk) begin
        if (!rst_n) begin
            clear_parse();
            awaited.delete();
            mismatches = 0;
        end else begin
            if (res_valid && !res_stall)
                check_result(res_beat);
            if (src_valid && !src_stall)
                parse_file_byte(src_beat.data_byte, src_beat.last_byte);
        end
        bad_results         <= mismatches;
        results_outstanding <= awaited.size();
    end

endmodule

### bench/voxel_chunk_stream_parser_tb.sv
// voxel_chunk_stream_parser_tb: drives whole voxel files byte by byte into the
// parser under varying idle and stall patterns and gives the verdict.
// Depends on vcsp_pkg, voxel_chunk_stream_parser and vcsp_result_checker.
module voxel_chunk_stream_parser_tb;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_BYTES = 320;
    localparam int DRAIN_CYCLES = 20;
    localparam int DENSE_VOXELS = 24;

    typedef enum logic [1:0] {
        IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH
    } idle_mode_e;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                src_valid = 1'b0;
    logic                src_stall;
    vcsp_pkg::src_beat_t src_beat  = '0;
    logic                res_valid;
    logic                res_stall = 1'b0;
    vcsp_pkg::res_beat_t res_beat;
    int                  bad_results;
    int                  results_outstanding;

    idle_mode_e idle_mode   = IDLE_NONE;
    int         hold_asked  = 0;
    int         hold_given  = 0;
    int         hold_left   = 0;
    int         cycle_count = 0;
    logic [7:0] file_bytes[$];

    always #6 clk = ~clk;

    voxel_chunk_stream_parser u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_beat  (src_beat),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_beat  (res_beat)
    );

    vcsp_result_checker u_checker (
        .clk                 (clk),
        .rst_n               (rst_n),
        .src_valid           (src_valid),
        .src_stall           (src_stall),
        .src_beat            (src_beat),
        .res_valid           (res_valid),
        .res_stall           (res_stall),
        .res_beat            (res_beat),
        .bad_results         (bad_results),
        .results_outstanding (results_outstanding)
    );

    function automatic int stall_pct(input idle_mode_e m);
        case (m)
            IDLE_RECEIVER: return 63;
            IDLE_BOTH:     return 21;
            default:       return 0;
        endcase
    endfunction

    function automatic int gap_pct(input idle_mode_e m);
        case (m)
            IDLE_SENDER: return 63;
            IDLE_BOTH:   return 21;
            default:     return 0;
        endcase
    endfunction

    // Watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("voxel_chunk_stream_parser_tb: errors");
            $finish;
        end
    end

    // Receiver: long hold-off on request, else random stalls per idle mode
    always @(posedge clk) begin
        if (hold_left != 0) begin
            res_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_asked != hold_given) begin
            res_stall  <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            hold_given <= hold_given + 1;
        end else begin
            res_stall <= ($urandom_range(99) < stall_pct(idle_mode));
        end
    end

    // Little-endian word into the file image
    function automatic void add_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++)
            file_bytes.push_back(w[8*i +: 8]);
    endfunction

    function automatic void add_noise(input int n);
        for (int i = 0; i < n; i++)
            file_bytes.push_back(8'($urandom()));
    endfunction

    function automatic logic [31:0] extreme_word();
        case ($urandom_range(3))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // Mostly well-formed files with random content, some noise and breakage
    function automatic void build_random_file(input bit dense);
        int          pick;
        int          n_chunks;
        int          len;
        int          kids;
        int          used;
        int          cnt;
        int          cut;
        bit          closed;
        logic [31:0] id;
        file_bytes.delete();
        closed = 1'b0;
        pick   = dense ? 50 : $urandom_range(99);

        if (pick < 8) begin
            add_noise($urandom_range(1, 12));
            return;
        end
        if (pick < 12)
            add_word(vcsp_pkg::ID_VOX ^ (32'd1 << $urandom_range(31)));
        else
            add_word(vcsp_pkg::ID_VOX);
        add_word($urandom());
        if (pick < 16)
            add_word(vcsp_pkg::ID_MAIN ^ (32'd1 << $urandom_range(31)));
        else
            add_word(vcsp_pkg::ID_MAIN);
        add_word($urandom());
        add_word($urandom());

        // Long voxel chunk followed by a size chunk
        if (dense) begin
            add_word(vcsp_pkg::ID_XYZI);
            add_word(32'(4 + 4 * DENSE_VOXELS));
            add_word(32'd0);
            add_word(32'(DENSE_VOXELS));
            for (int i = 0; i < DENSE_VOXELS; i++)
                add_word($urandom());
            add_word(vcsp_pkg::ID_SIZE);
            add_word(32'd12);
            add_word(32'd0);
            for (int i = 0; i < 3; i++)
                add_word(extreme_word());
            return;
        end

        n_chunks = $urandom_range(0, 4);
        for (int c = 0; c < n_chunks && !closed; c++) begin
            pick = $urandom_range(99);
            kids = ($urandom_range(3) == 0) ? $urandom_range(1, 8) : 0;
            len  = 0;
            used = 0;
            if (pick < 30) begin
                // size chunk, sometimes declared short or long
                len = ($urandom_range(3) == 0) ? $urandom_range(0, 20) : 12;
                add_word(vcsp_pkg::ID_SIZE);
                add_word(len);
                add_word(kids);
                for (int i = 0; i < 3; i++)
                    add_word(extreme_word());
                used = 12;
            end else if (pick < 55) begin
                cnt = $urandom_range(0, 6);
                len = ($urandom_range(4) == 0) ? $urandom_range(0, 40) : 4 + 4 * cnt;
                add_word(vcsp_pkg::ID_XYZI);
                add_word(len);
                add_word(kids);
                if ($urandom_range(9) == 0) begin
                    // huge voxel count, file ends inside the data
                    add_word($urandom() | 32'h100);
                    closed = 1'b1;
                end else begin
                    add_word(cnt);
                end
                for (int i = 0; i < cnt; i++)
                    add_word($urandom());
                used = 4 + 4 * cnt;
            end else if (pick < 70) begin
                // palette cut short by the end of the file
                add_word(vcsp_pkg::ID_RGBA);
                add_word(32'd1024);
                add_word(kids);
                cnt = $urandom_range(0, 8);
                for (int i = 0; i < cnt; i++)
                    add_word(extreme_word());
                closed = 1'b1;
            end else if (pick < 85) begin
                id = $urandom();
                if (id == 0)
                    id = 32'd1;
                len = $urandom_range(0, 12);
                add_word(id);
                add_word(len);
                add_word(kids);
                add_noise(len);
                used = len;
            end else if (pick < 92) begin
                // enormous lengths, file ends during the skip
                add_word($urandom() | 32'd1);
                add_word($urandom_range(1) ? 32'hFFFF_FFFF : $urandom());
                add_word($urandom_range(1) ? 32'hFFFF_FFFF : $urandom());
                add_noise($urandom_range(0, 10));
                closed = 1'b1;
            end else begin
                // zero id ends the chunk walk
                add_word(32'd0);
                add_noise($urandom_range(0, 6));
                closed = 1'b1;
            end
            if (!closed && len + kids > used)
                add_noise(len + kids - used);
        end

        // partial trailing word
        if (!closed && $urandom_range(3) == 0)
            add_noise($urandom_range(1, 3));
        // cut anywhere
        if ($urandom_range(4) == 0) begin
            cut = $urandom_range(1, file_bytes.size());
            while (file_bytes.size() > cut)
                void'(file_bytes.pop_back());
        end
    endfunction

    // One byte beat; valid stays up and the payload steady until taken
    task automatic send_beat(input logic [7:0] b, input logic lst);
        while (gap_pct(idle_mode) != 0 && $urandom_range(99) < gap_pct(idle_mode)) begin
            src_valid <= 1'b0;
            @(posedge clk);
        end
        src_valid <= 1'b1;
        src_beat  <= '{data_byte: b, last_byte: lst};
        @(posedge clk);
        while (src_stall)
            @(posedge clk);
    endtask

    task automatic send_file();
        for (int i = 0; i < file_bytes.size(); i++)
            send_beat(file_bytes[i], i == file_bytes.size() - 1);
    endtask

    initial begin
        int random_sent;
        int file_no;
        random_sent = 0;
        file_no     = 0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: one-byte file, bad magic with trailing bytes,
        // end after the version, wrong main id
        file_bytes.delete();
        file_bytes.push_back(8'hFF);
        send_file();
        file_bytes.delete();
        add_word(32'h0000_0000);
        file_bytes.push_back(8'hFF);
        file_bytes.push_back(8'h00);
        send_file();
        file_bytes.delete();
        add_word(vcsp_pkg::ID_VOX);
        add_word(32'hFFFF_FFFF);
        send_file();
        file_bytes.delete();
        add_word(vcsp_pkg::ID_VOX);
        add_word(32'h0000_0000);
        add_word(vcsp_pkg::ID_MAIN ^ 32'h8000_0000);
        send_file();

        // Long receiver hold-off during a long voxel chunk, sender never idle
        build_random_file(1'b1);
        hold_asked <= hold_asked + 1;
        send_file();

        // Random files, idle mode changing every two files
        while (random_sent < RANDOM_BYTES) begin
            idle_mode <= idle_mode_e'((file_no / 2) % 4);
            build_random_file(1'b0);
            random_sent += file_bytes.size();
            send_file();
            file_no++;
        end
        src_valid <= 1'b0;

        @(posedge clk);
        while (results_outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (bad_results == 0 && results_outstanding == 0)
            $display("voxel_chunk_stream_parser_tb: clean");
        else
            $display("voxel_chunk_stream_parser_tb: errors");
        $finish;
    end

endmodule
